[design/smmrs_pkg.sv]
// Shared constants and types of the sample min/max/RMS statistics unit.
`default_nettype none

package smmrs_pkg;

   // Longest run that enters the statistics; later samples are dropped.
   localparam int MAX_COUNT = 128;

   localparam int SAMPLE_W  = 16;
   localparam int OUT_CNT_W = 8;
   localparam int RMS_W     = 16;

   // Sample counter holds 0 to MAX_COUNT.
   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   // A square of a 16-bit signed sample is at most 2^30.
   localparam int SQR_W = 2 * SAMPLE_W - 1;

   // Sum of squares over MAX_COUNT samples.
   localparam int SUM_W = SQR_W + $clog2(MAX_COUNT);

   // Square root works on an even number of bits, two per step.
   localparam int SQ_W   = SUM_W + (SUM_W % 2);
   localparam int HALF_W = SQ_W / 2;

   // Step counter of the divider and the square root unit.
   localparam int STEP_W = $clog2(SUM_W + 1);

   // Run queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Totals of one finished run, handed from front to back.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic [SUM_W-1:0]           square_sum;
      logic [CNT_W-1:0]           count;
      logic                       dropped;
   } run_type;

endpackage

`default_nettype wire

[design/smmrs_if.sv]
// Valid/ready channels of the statistics unit: sample words in, result words out.
`default_nettype none

interface smmrs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [smmrs_pkg::SAMPLE_W-1:0] sample;
   logic                                  last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface smmrs_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [smmrs_pkg::SAMPLE_W-1:0]  min_value;
   logic signed [smmrs_pkg::SAMPLE_W-1:0]  max_value;
   logic [smmrs_pkg::SAMPLE_W-1:0]         peak_to_peak;
   logic [smmrs_pkg::RMS_W-1:0]            rms_value;
   logic [smmrs_pkg::OUT_CNT_W-1:0]        sample_count;
   logic                                   overflow;

   modport source (output valid, output min_value, output max_value, output peak_to_peak,
                   output rms_value, output sample_count, output overflow, input ready);
   modport sink   (input valid, input min_value, input max_value, input peak_to_peak,
                   input rms_value, input sample_count, input overflow, output ready);
endinterface

`default_nettype wire

[design/smmrs_front.sv]
// Front end: squares each sample and keeps the running min, max, count and sum of squares.
`default_nettype none

module smmrs_front (
   input  wire logic             clock,
   input  wire logic             reset,
   smmrs_req_if.sink             req,
   output logic                  push_valid,
   output smmrs_pkg::run_type    push_data,
   input  wire logic             push_ready
);

   // Sample stage: registered sample and its square
   logic                                  valid_a_ff, valid_a_in;
   logic signed [smmrs_pkg::SAMPLE_W-1:0] sample_a_ff, sample_a_in;
   logic [smmrs_pkg::SQR_W-1:0]           square_a_ff, square_a_in;
   logic                                  last_a_ff, last_a_in;

   // Run accumulators
   logic signed [smmrs_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic signed [smmrs_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic [smmrs_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [smmrs_pkg::CNT_W-1:0]           count_ff, count_in;
   logic                                  dropped_ff, dropped_in;

   logic signed [2*smmrs_pkg::SAMPLE_W-1:0] product;
   logic                                    req_take;
   logic                                    consume_a;
   logic                                    room;
   logic                                    first;
   logic signed [smmrs_pkg::SAMPLE_W-1:0]   min_next;
   logic signed [smmrs_pkg::SAMPLE_W-1:0]   max_next;
   logic [smmrs_pkg::SUM_W-1:0]             sum_next;
   logic [smmrs_pkg::CNT_W-1:0]             count_next;
   logic                                    dropped_next;

   // Retire the held word unless it closes a run and the queue is full
   assign consume_a  = valid_a_ff && (!last_a_ff || push_ready);
   assign req.ready  = !valid_a_ff || consume_a;
   assign req_take   = req.valid && req.ready;
   assign product    = req.sample * req.sample;

   // Load the sample stage
   always_comb begin
      valid_a_in  = valid_a_ff;
      sample_a_in = sample_a_ff;
      square_a_in = square_a_ff;
      last_a_in   = last_a_ff;
      if (req_take) begin
         valid_a_in  = 1'b1;
         sample_a_in = req.sample;
         square_a_in = product[smmrs_pkg::SQR_W-1:0];
         last_a_in   = req.last;
      end else if (consume_a) begin
         valid_a_in = 1'b0;
      end
   end

   // Fold the held sample into the totals, or drop it once the run is full
   assign room  = count_ff < smmrs_pkg::CNT_W'(smmrs_pkg::MAX_COUNT);
   assign first = count_ff == '0;

   always_comb begin
      min_next     = min_ff;
      max_next     = max_ff;
      sum_next     = sum_ff;
      count_next   = count_ff;
      dropped_next = dropped_ff;
      if (room) begin
         if (first || (sample_a_ff < min_ff)) min_next = sample_a_ff;
         if (first || (sample_a_ff > max_ff)) max_next = sample_a_ff;
         sum_next   = sum_ff + smmrs_pkg::SUM_W'(square_a_ff);
         count_next = count_ff + 1'b1;
      end else begin
         dropped_next = 1'b1;
      end
   end

   // Hand the finished run to the queue
   assign push_valid           = valid_a_ff && last_a_ff;
   assign push_data.min_value  = min_next;
   assign push_data.max_value  = max_next;
   assign push_data.square_sum = sum_next;
   assign push_data.count      = count_next;
   assign push_data.dropped    = dropped_next;

   // Advance totals, clear them after the last word of a run
   always_comb begin
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (consume_a) begin
         if (last_a_ff) begin
            min_in     = '0;
            max_in     = '0;
            sum_in     = '0;
            count_in   = '0;
            dropped_in = 1'b0;
         end else begin
            min_in     = min_next;
            max_in     = max_next;
            sum_in     = sum_next;
            count_in   = count_next;
            dropped_in = dropped_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_a_ff <= sample_a_in;
      square_a_ff <= square_a_in;
      last_a_ff   <= last_a_in;
      if (reset) begin
         valid_a_ff <= 1'b0;
         min_ff     <= '0;
         max_ff     <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

`default_nettype wire

[design/smmrs_queue.sv]
// Short queue of finished runs between the front end and the back end.
`default_nettype none

module smmrs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire smmrs_pkg::run_type  push_data,
   output logic                     push_ready,
   output logic                     pop_valid,
   output smmrs_pkg::run_type       pop_data,
   input  wire logic                pop_ready
);

   smmrs_pkg::run_type               entry_ff [smmrs_pkg::QUEUE_DEPTH];
   smmrs_pkg::run_type               entry_in;
   logic [smmrs_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [smmrs_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [smmrs_pkg::QCNT_W-1:0]     fill_ff, fill_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = fill_ff != smmrs_pkg::QCNT_W'(smmrs_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign entry_in   = push_data;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == smmrs_pkg::QPTR_W'(smmrs_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == smmrs_pkg::QPTR_W'(smmrs_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (!do_push && do_pop) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= entry_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[design/smmrs_back.sv]
// Back end: divides the sum of squares by the count, takes the square root, sends the result.
`default_nettype none

module smmrs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  wire smmrs_pkg::run_type  pop_data,
   output logic                     pop_ready,
   smmrs_rsp_if.source              rsp
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_SEND = 4'b1000
   } back_state_type;

   back_state_type                        state_ff, state_in;
   logic signed [smmrs_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic signed [smmrs_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic [smmrs_pkg::SAMPLE_W-1:0]        p2p_ff, p2p_in;
   logic [smmrs_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic                                  ovf_ff, ovf_in;
   logic [smmrs_pkg::CNT_W-1:0]           rem_ff, rem_in;
   logic [smmrs_pkg::SUM_W-1:0]           quo_ff, quo_in;
   logic [smmrs_pkg::SQ_W-1:0]            val_ff, val_in;
   logic [smmrs_pkg::HALF_W+1:0]          srem_ff, srem_in;
   logic [smmrs_pkg::HALF_W-1:0]          root_ff, root_in;
   logic [smmrs_pkg::STEP_W-1:0]          step_ff, step_in;

   logic [smmrs_pkg::CNT_W:0]             div_shift;
   logic [smmrs_pkg::CNT_W:0]             div_sub;
   logic                                  div_ge;
   logic [smmrs_pkg::HALF_W+1:0]          sq_shift;
   logic [smmrs_pkg::HALF_W+1:0]          sq_trial;
   logic [smmrs_pkg::HALF_W+1:0]          sq_sub;
   logic                                  sq_ge;
   logic                                  div_done;
   logic                                  root_done;

   // One restoring division step: one quotient bit
   assign div_shift = {rem_ff, quo_ff[smmrs_pkg::SUM_W-1]};
   assign div_ge    = div_shift >= {1'b0, cnt_ff};
   assign div_sub   = div_shift - {1'b0, cnt_ff};
   assign div_done  = step_ff == smmrs_pkg::STEP_W'(smmrs_pkg::SUM_W - 1);

   // One square root step: two radicand bits, one root bit
   assign sq_shift  = {srem_ff[smmrs_pkg::HALF_W-1:0], val_ff[smmrs_pkg::SQ_W-1 -: 2]};
   assign sq_trial  = {root_ff, 2'b01};
   assign sq_ge     = sq_shift >= sq_trial;
   assign sq_sub    = sq_shift - sq_trial;
   assign root_done = step_ff == smmrs_pkg::STEP_W'(smmrs_pkg::HALF_W - 1);

   assign pop_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      p2p_in   = p2p_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      val_in   = val_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            // Take a finished run and start the division
            if (pop_valid) begin
               min_in   = pop_data.min_value;
               max_in   = pop_data.max_value;
               p2p_in   = pop_data.max_value - pop_data.min_value;
               cnt_in   = pop_data.count;
               ovf_in   = pop_data.dropped;
               rem_in   = '0;
               quo_in   = pop_data.square_sum;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? div_sub[smmrs_pkg::CNT_W-1:0] : div_shift[smmrs_pkg::CNT_W-1:0];
            quo_in  = {quo_ff[smmrs_pkg::SUM_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (div_done) begin
               // Mean square is ready next cycle in quo; start the root on it
               state_in = ST_ROOT;
               step_in  = '0;
               srem_in  = '0;
               root_in  = '0;
               val_in   = (cnt_ff == '0) ? '0
                          : smmrs_pkg::SQ_W'({quo_ff[smmrs_pkg::SUM_W-2:0], div_ge});
            end
         end
         ST_ROOT: begin
            srem_in = sq_ge ? sq_sub : sq_shift;
            root_in = {root_ff[smmrs_pkg::HALF_W-2:0], sq_ge};
            val_in  = {val_ff[smmrs_pkg::SQ_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (root_done) state_in = ST_SEND;
         end
         ST_SEND: begin
            // Hold the result until it is taken
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid        = state_ff == ST_SEND;
   assign rsp.min_value    = min_ff;
   assign rsp.max_value    = max_ff;
   assign rsp.peak_to_peak = p2p_ff;
   assign rsp.rms_value    = root_ff[smmrs_pkg::RMS_W-1:0];
   assign rsp.sample_count = smmrs_pkg::OUT_CNT_W'(cnt_ff);
   assign rsp.overflow     = ovf_ff;

   always_ff @(posedge clock) begin
      min_ff  <= min_in;
      max_ff  <= max_in;
      p2p_ff  <= p2p_in;
      cnt_ff  <= cnt_in;
      ovf_ff  <= ovf_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      val_ff  <= val_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

[design/sample_min_max_rms_stats_unit.sv]
// Top level of the sample min/max/peak-to-peak/RMS statistics unit.
// Takes one signed Q8.8 sample word per cycle unless stalled; a word with last set closes
// the run and yields one result word with min, max, peak-to-peak, RMS (floor square root
// of the floor of the mean square), the sample count and a flag for samples dropped past
// MAX_COUNT. The front end squares each word into a registered sample stage and
// accumulates at one word per cycle. Each run then costs the back end SUM_W division
// steps plus SQ_W/2 root steps (38 + 19 at MAX_COUNT = 128) plus a load and a send
// state, one bit per step in a shared divider and root unit; a two-run queue sits
// between the two, so runs longer than the back end's work per run stream at one word
// per cycle and shorter runs are limited by the back end. No clearing pass after reset.
`default_nettype none

module sample_min_max_rms_stats_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   smmrs_req_if.sink    req_bus,
   smmrs_rsp_if.source  rsp_bus
);

   logic               push_valid;
   logic               push_ready;
   smmrs_pkg::run_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   smmrs_pkg::run_type pop_data;

   smmrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   smmrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   smmrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

[design/smmrs_checker.sv]
// Port-level checks of the statistics unit and their attachment to the top level.
`default_nettype none

module smmrs_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic signed [smmrs_pkg::SAMPLE_W-1:0] rsp_min_value,
   input wire logic signed [smmrs_pkg::SAMPLE_W-1:0] rsp_max_value,
   input wire logic [smmrs_pkg::SAMPLE_W-1:0]        rsp_peak_to_peak,
   input wire logic [smmrs_pkg::RMS_W-1:0]           rsp_rms_value,
   input wire logic [smmrs_pkg::OUT_CNT_W-1:0]       rsp_sample_count,
   input wire logic                                  rsp_overflow
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_value)
         && $stable(rsp_max_value) && $stable(rsp_rms_value) && $stable(rsp_sample_count))
      else $error("result word changed while stalled");

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Extremes are ordered and peak-to-peak is their difference
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_value <= rsp_max_value)
         && (rsp_peak_to_peak == smmrs_pkg::SAMPLE_W'(rsp_max_value - rsp_min_value)))
      else $error("min, max and peak-to-peak disagree");

   // Overflow only on a full run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_sample_count == smmrs_pkg::OUT_CNT_W'(smmrs_pkg::MAX_COUNT))
      else $error("overflow flagged on a run short of the maximum count");

endmodule

bind sample_min_max_rms_stats_unit smmrs_checker u_smmrs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_min_value    (rsp_bus.min_value),
   .rsp_max_value    (rsp_bus.max_value),
   .rsp_peak_to_peak (rsp_bus.peak_to_peak),
   .rsp_rms_value    (rsp_bus.rms_value),
   .rsp_sample_count (rsp_bus.sample_count),
   .rsp_overflow     (rsp_bus.overflow)
);

`default_nettype wire

[tb/sample_min_max_rms_stats_unit_tb.sv]
// Self-checking testbench of the sample min/max/RMS statistics unit: directed table then random runs.
`default_nettype none

module sample_min_max_rms_stats_unit_tb;

   localparam int SAMPLE_W  = smmrs_pkg::SAMPLE_W;
   localparam int RMS_W     = smmrs_pkg::RMS_W;
   localparam int OUT_CNT_W = smmrs_pkg::OUT_CNT_W;
   localparam int SUM_W     = smmrs_pkg::SUM_W;
   localparam int CNT_W     = smmrs_pkg::CNT_W;
   localparam int MAX_COUNT = smmrs_pkg::MAX_COUNT;

   localparam int WORD_TARGET  = 1250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 200;

   localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

   // One result word of a finished run
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic [SAMPLE_W-1:0]        peak_to_peak;
      logic [RMS_W-1:0]           rms_value;
      logic [OUT_CNT_W-1:0]       sample_count;
      logic                       overflow;
   } stats_type;

   // Directed stimulus row: a sample repeated reps times, last only on the final copy
   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      int                         reps;
      bit                         last;
      bit                         typed;
      stats_type                  want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   smmrs_req_if req_bus ();
   smmrs_rsp_if rsp_bus ();

   sample_min_max_rms_stats_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Running statistics of the run in progress
   logic signed [SAMPLE_W-1:0] run_min     = '0;
   logic signed [SAMPLE_W-1:0] run_max     = '0;
   logic [SUM_W-1:0]           run_sq_sum  = '0;
   logic [CNT_W-1:0]           run_n       = '0;
   logic                       run_dropped = 1'b0;

   stats_type stats_due[$];
   row_type   plan[$];
   int        mismatches = 0;
   int        words_sent = 0;
   int        send_calm  = 0;
   int        recv_calm  = 0;
   int        quiet      = 0;

   // Sideband that travels with the word in flight: a typed-in result for the run it closes
   bit        word_typed;
   stats_type word_want;

   // Floor square root, found one result bit at a time from the top
   function automatic logic [RMS_W-1:0] floor_root(input logic [SUM_W-1:0] v);
      longint unsigned acc;
      longint unsigned trial;
      acc = 0;
      for (int i = RMS_W - 1; i >= 0; i--) begin
         trial = acc | (64'd1 << i);
         if (trial * trial <= v) acc = trial;
      end
      return RMS_W'(acc);
   endfunction

   // Fold one accepted sample into the run; on last, hand back the run's statistics and clear
   task automatic fold_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
                              output logic done, output stats_type res);
      longint           sq;
      logic [SUM_W-1:0] mean;
      done = l;
      res  = '0;
      if (run_n < MAX_COUNT) begin
         if (run_n == 0) begin
            run_min = s;
            run_max = s;
         end else begin
            if (s < run_min) run_min = s;
            if (s > run_max) run_max = s;
         end
         sq         = longint'(s) * longint'(s);
         run_sq_sum = run_sq_sum + SUM_W'(sq);
         run_n      = run_n + 1'b1;
      end else begin
         run_dropped = 1'b1;
      end
      if (l) begin
         mean             = (run_n != 0) ? run_sq_sum / run_n : '0;
         res.min_value    = run_min;
         res.max_value    = run_max;
         res.peak_to_peak = run_max - run_min;
         res.rms_value    = floor_root(mean);
         res.sample_count = OUT_CNT_W'(run_n);
         res.overflow     = run_dropped;
         run_min          = '0;
         run_max          = '0;
         run_sq_sum       = '0;
         run_n            = '0;
         run_dropped      = 1'b0;
      end
   endtask

   task automatic check_stats(input stats_type want, input stats_type got);
      if (got.min_value !== want.min_value) begin
         $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
         mismatches++;
      end
      if (got.max_value !== want.max_value) begin
         $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
         mismatches++;
      end
      if (got.peak_to_peak !== want.peak_to_peak) begin
         $error("peak_to_peak: expected %0d, got %0d", want.peak_to_peak, got.peak_to_peak);
         mismatches++;
      end
      if (got.rms_value !== want.rms_value) begin
         $error("rms_value: expected %0d, got %0d", want.rms_value, got.rms_value);
         mismatches++;
      end
      if (got.sample_count !== want.sample_count) begin
         $error("sample_count: expected %0d, got %0d", want.sample_count, got.sample_count);
         mismatches++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
         mismatches++;
      end
   endtask

   // Idle cycles before the next word; calm stretches hold the gap at zero
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 5);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return $urandom_range(0, 1) ? '1 : '0;
         3, 4: return $signed(SAMPLE_W'($urandom_range(0, 511))) - 16'sd256;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic add_row(input logic signed [SAMPLE_W-1:0] s, input int reps, input bit l);
      row_type r;
      r.sample = s;
      r.reps   = reps;
      r.last   = l;
      r.typed  = 1'b0;
      r.want   = '0;
      plan.push_back(r);
   endtask

   // Row that closes its run with a result readable at a glance
   task automatic add_typed(input logic signed [SAMPLE_W-1:0] s, input int reps,
                            input int mn, input int mx, input int p2p, input int rms,
                            input int cnt, input int ovf);
      row_type r;
      r.sample            = s;
      r.reps              = reps;
      r.last              = 1'b1;
      r.typed             = 1'b1;
      r.want.min_value    = SAMPLE_W'(mn);
      r.want.max_value    = SAMPLE_W'(mx);
      r.want.peak_to_peak = SAMPLE_W'(p2p);
      r.want.rms_value    = RMS_W'(rms);
      r.want.sample_count = OUT_CNT_W'(cnt);
      r.want.overflow     = ovf[0];
      plan.push_back(r);
   endtask

   // Drive one sample word at a falling edge and hold it until accepted
   task automatic put_word(input logic signed [SAMPLE_W-1:0] s, input logic l,
                           input bit typed, input stats_type want);
      int gap;
      gap = draw_gap(send_calm);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      req_bus.last   <= l;
      word_typed     <= typed;
      word_want      <= want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every pending result word has arrived
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (stats_due.size() != 0);
   endtask

   // Predict on accepted sample words, check accepted result words
   always @(posedge clock) begin
      logic      done;
      stats_type guess;
      stats_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            fold_sample(req_bus.sample, req_bus.last, done, guess);
            if (done) stats_due.push_back(word_typed ? word_want : guess);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.min_value    = rsp_bus.min_value;
            got.max_value    = rsp_bus.max_value;
            got.peak_to_peak = rsp_bus.peak_to_peak;
            got.rms_value    = rsp_bus.rms_value;
            got.sample_count = rsp_bus.sample_count;
            got.overflow     = rsp_bus.overflow;
            if (stats_due.size() == 0) begin
               $error("result word with no run pending");
               mismatches++;
            end else begin
               check_stats(stats_due.pop_front(), got);
            end
         end
      end
   end

   // Stop a hung run: count cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet <= 0;
      end else if (quiet == IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Result side: stall for a drawn number of cycles once a word shows, or take it at once
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_gap(recv_calm);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
            while (!rsp_bus.valid) @(posedge clock);
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Sample side: directed table, then random runs
   initial begin
      int len;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      req_bus.last   = 1'b0;
      word_typed     = 1'b0;
      word_want      = '0;

      // Single-sample runs at zero, both extremes and minus one
      add_typed('0, 1, 0, 0, 0, 0, 1, 0);
      add_typed(MOST_POS, 1, 32767, 32767, 0, 32767, 1, 0);
      add_typed(MOST_NEG, 1, -32768, -32768, 0, 32768, 1, 0);
      add_typed('1, 1, -1, -1, 0, 1, 1, 0);
      // Widest peak-to-peak
      add_row(MOST_NEG, 1, 1'b0);
      add_typed(MOST_POS, 1, -32768, 32767, 65535, 32767, 2, 0);
      // Alternating bit patterns and mixed signs
      add_row(16'sh5555, 1, 1'b0);
      add_row(16'shAAAA, 1, 1'b0);
      add_row(16'sd256, 1, 1'b0);
      add_row(-16'sd256, 1, 1'b1);
      add_row(16'sd100, 1, 1'b0);
      add_row(-16'sd50, 1, 1'b0);
      add_row(16'sd3, 1, 1'b1);
      // Full run of the most negative sample, then a dropped last word that would raise max
      add_row(MOST_NEG, MAX_COUNT, 1'b0);
      add_typed(MOST_POS, 1, -32768, -32768, 0, 32768, MAX_COUNT, 1);
      add_row(16'sd7, 3, 1'b1);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int r = 0; r < plan[i].reps; r++)
            put_word(plan[i].sample, plan[i].last && (r == plan[i].reps - 1),
                     plan[i].typed, plan[i].want);
      end
      hold_until_drained();

      // Random runs: mostly short, some filling or overrunning MAX_COUNT
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 9) == 0) hold_until_drained();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(1, 4);
            5, 6, 7:       len = $urandom_range(5, 24);
            8:             len = $urandom_range(MAX_COUNT - 3, MAX_COUNT + 12);
            default:       len = 1;
         endcase
         for (int r = 0; r < len; r++) put_word(pick_sample(), r == len - 1, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      // Drain, then allow time for any stray result word
      while (stats_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
